// ===== src/stack_machine_execute_core_assert.svh =====
// assertion macros for the stack machine execute core
// used by the top level; expects clk_i and rst_ni in scope
`ifndef STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/smc_pkg.sv =====
// shared types, opcodes and constants of the stack machine execute core
// no dependencies
package smc_pkg;

  localparam int STACK_AW    = 8;
  localparam int STACK_DEPTH = 1 << STACK_AW;

  typedef logic [STACK_AW-1:0] sptr_t;

  localparam logic [31:0] TRUE_WORD = 32'hFFFF_FFFF;
  localparam int          LITS_SHIFT = 7;

  typedef enum logic [5:0] {
    OP_INVALID     = 6'd0,
    OP_EXCEPTION   = 6'd1,
    OP_JSR_C       = 6'd2,
    OP_JMP_C       = 6'd3,
    OP_JZ_C        = 6'd4,
    OP_ADD_C       = 6'd5,
    OP_RGET_C      = 6'd6,
    OP_RSET_C      = 6'd7,
    OP_TWODUP      = 6'd8,
    OP_LIT         = 6'd9,
    OP_LITS        = 6'd10,
    OP_RET         = 6'd11,
    OP_JSR         = 6'd12,
    OP_JMP         = 6'd13,
    OP_JZ          = 6'd14,
    OP_EQ0         = 6'd15,
    OP_EQ          = 6'd16,
    OP_ULT         = 6'd17,
    OP_LT          = 6'd18,
    OP_AND         = 6'd19,
    OP_OR          = 6'd20,
    OP_XOR         = 6'd21,
    OP_ADD         = 6'd22,
    OP_SUB         = 6'd23,
    OP_CSEL        = 6'd24,
    OP_UMUL        = 6'd25,
    OP_UDIV        = 6'd26,
    OP_RD          = 6'd27,
    OP_WRT         = 6'd28,
    OP_RDB         = 6'd29,
    OP_WRTB        = 6'd30,
    OP_SIGNE       = 6'd31,
    OP_SHL         = 6'd32,
    OP_USHR        = 6'd33,
    OP_SHR         = 6'd34,
    OP_NOP         = 6'd35,
    OP_DUP         = 6'd36,
    OP_DROP        = 6'd37,
    OP_SWAP        = 6'd38,
    OP_OVER        = 6'd39,
    OP_ROT         = 6'd40,
    OP_RTO         = 6'd41,
    OP_RFROM       = 6'd42,
    OP_RGET        = 6'd43,
    OP_RSET        = 6'd44,
    OP_LOAD_RETURN = 6'd45,
    OP_REARM       = 6'd46
  } op_e;

  typedef enum logic [2:0] {
    MEM_NONE    = 3'd0,
    MEM_RD_WORD = 3'd1,
    MEM_RD_BYTE = 3'd2,
    MEM_WR_WORD = 3'd3,
    MEM_WR_BYTE = 3'd4
  } mem_op_e;

  typedef enum logic [1:0] {
    CFG_TRAP_START = 2'd0,
    CFG_CODE_DBZ   = 2'd1,
    CFG_CODE_INV   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_DIV,
    ST_EXEC,
    ST_WR2,
    ST_OUT
  } state_e;

  typedef enum logic {
    RD_TOP,
    RD_SECOND
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    rd_sel_e rd_sel;
    logic    cap_first;
    logic    cap_second;
    logic    mul_go;
    logic    div_init;
    logic    div_step;
    logic    exec;
    logic    wr_second;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
    logic has_w1;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/smc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module smc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/smc_datapath.sv =====
// datapath: machine registers, stacks, multiplier, divider, result register
// depends on smc_pkg and smc_ram
module smc_datapath import smc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [5:0]  opcode_i,
  input  logic [31:0] constant_i,
  input  logic [11:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [31:0] acc_out_o,
  output logic [2:0]  mem_op_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] mem_wdata_o,
  output logic        halted_o,
  output logic [31:0] halt_code_o
);

  logic [31:0] trap_start_q, code_dbz_q, code_inv_q;
  logic [5:0]  op_q;
  logic [31:0] k_q;
  logic [11:0] len_q;
  logic [31:0] pc_q, acc_q, hcode_q;
  sptr_t       dp_q, rp_q;
  logic        armed_q, stopped_q;
  logic [31:0] v1_q, v2_q, r_q;
  logic [63:0] prod_q;
  logic [31:0] rem_q, quo_q;
  logic [4:0]  dcnt_q;
  logic [STACK_DEPTH-1:0] ds_vld_q, rs_vld_q;
  logic        ds_rv_q, rs_rv_q;
  logic [31:0] ds_rdata, rs_rdata;
  sptr_t       ds_raddr, rs_raddr, rslot_off;
  mem_op_e     mop_q;
  logic [31:0] maddr_q, mdata_q;
  logic        w1_en_q;
  sptr_t       w1_addr_q;
  logic [31:0] w1_data_q;
  logic        ds_we, rs_we;
  sptr_t       ds_waddr;
  logic [31:0] ds_wdata;

  // exec results
  logic [31:0] pc_n, acc_n, hcode_n, maddr_n, mdata_n;
  sptr_t       dp_n, rp_n;
  logic        armed_n, stopped_n;
  mem_op_e     mop_n;
  logic        w0_en, w1_en, rw_en, trap;
  sptr_t       w0_addr, w1_addr, rw_addr;
  logic [31:0] w0_data, w1_data, rw_data, trap_code;
  logic [31:0] pc1, pcl, sext;
  logic [5:0]  sh;
  logic [32:0] div_r;
  logic [31:0] div_q;

  logic        out_vld_q;
  logic [31:0] out_pc_q, out_acc_q, out_maddr_q, out_mdata_q, out_hcode_q;
  logic [2:0]  out_mop_q;
  logic        out_halt_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_start_q <= '0;
      code_dbz_q   <= 32'd1;
      code_inv_q   <= 32'd2;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TRAP_START: trap_start_q <= cfg_data_i;
        CFG_CODE_DBZ:   code_dbz_q   <= cfg_data_i;
        CFG_CODE_INV:   code_inv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stack reads
  always_comb begin
    case (op_e'(op_q))
      OP_RGET_C: rslot_off = k_q[STACK_AW-1:0];
      OP_RGET:   rslot_off = acc_q[STACK_AW-1:0];
      default:   rslot_off = '0;
    endcase
    rs_raddr = rp_q - sptr_t'(1) - rslot_off;
    ds_raddr = (cmd_i.rd_sel == RD_SECOND) ? dp_q - sptr_t'(2) : dp_q - sptr_t'(1);
  end

  smc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_dstack (
    .clk_i, .we_i(ds_we), .waddr_i(ds_waddr), .wdata_i(ds_wdata),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata)
  );

  smc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_rstack (
    .clk_i, .we_i(rs_we), .waddr_i(rw_addr), .wdata_i(rw_data),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  assign ds_we    = (cmd_i.exec && w0_en) || (cmd_i.wr_second && w1_en_q);
  assign ds_waddr = cmd_i.wr_second ? w1_addr_q : w0_addr;
  assign ds_wdata = cmd_i.wr_second ? w1_data_q : w0_data;
  assign rs_we    = cmd_i.exec && rw_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_vld_q <= '0;
      rs_vld_q <= '0;
      ds_rv_q  <= 1'b0;
      rs_rv_q  <= 1'b0;
    end else begin
      ds_rv_q <= ds_vld_q[ds_raddr];
      rs_rv_q <= rs_vld_q[rs_raddr];
      if (ds_we) begin
        ds_vld_q[ds_waddr] <= 1'b1;
      end
      if (rs_we) begin
        rs_vld_q[rw_addr] <= 1'b1;
      end
    end
  end

  // operand capture, multiplier, divider
  assign div_r = {rem_q, quo_q[31]};
  assign div_q = {quo_q[30:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      k_q   <= constant_i;
      len_q <= length_i;
    end
    if (cmd_i.cap_first) begin
      v1_q <= ds_rv_q ? ds_rdata : '0;
      r_q  <= rs_rv_q ? rs_rdata : '0;
    end
    if (cmd_i.cap_second) begin
      v2_q <= ds_rv_q ? ds_rdata : '0;
    end
    if (cmd_i.mul_go) begin
      prod_q <= 64'(v1_q) * 64'(acc_q);
    end
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      quo_q  <= v1_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (div_r >= {1'b0, acc_q}) begin
        rem_q <= 32'(div_r - {1'b0, acc_q});
        quo_q <= div_q | 32'd1;
      end else begin
        rem_q <= div_r[31:0];
        quo_q <= div_q;
      end
    end
    if (cmd_i.exec) begin
      mop_q     <= mop_n;
      maddr_q   <= maddr_n;
      mdata_q   <= mdata_n;
      w1_en_q   <= w1_en;
      w1_addr_q <= w1_addr;
      w1_data_q <= w1_data;
    end
  end

  // instruction execution
  assign pc1 = pc_q + 32'd1;
  assign pcl = pc_q + 32'(len_q);
  assign sh  = 6'd32 - {1'b0, acc_q[4:0]};

  always_comb begin
    if (acc_q[31:5] != '0) begin
      sext = v1_q;
    end else if (acc_q[4:0] == '0) begin
      sext = '0;
    end else begin
      sext = 32'($signed(v1_q << sh) >>> sh);
    end
  end

  always_comb begin
    pc_n = pc_q; acc_n = acc_q; dp_n = dp_q; rp_n = rp_q;
    armed_n = armed_q; stopped_n = stopped_q; hcode_n = hcode_q;
    mop_n = MEM_NONE; maddr_n = '0; mdata_n = '0;
    w0_en = 1'b0; w0_addr = dp_q; w0_data = acc_q;
    w1_en = 1'b0; w1_addr = dp_q + sptr_t'(1); w1_data = v1_q;
    rw_en = 1'b0; rw_addr = rp_q; rw_data = pc_q;
    trap = 1'b0; trap_code = code_inv_q;
    if (!stopped_q) begin
      case (op_e'(op_q))
        OP_JSR_C: begin
          rw_en = 1'b1; rw_data = pcl; rp_n = rp_q + sptr_t'(1); pc_n = k_q;
        end
        OP_JMP_C: pc_n = k_q;
        OP_JZ_C: begin
          pc_n = (acc_q == '0) ? k_q : pcl; acc_n = v1_q; dp_n = dp_q - sptr_t'(1);
        end
        OP_ADD_C: begin
          pc_n = pcl; acc_n = acc_q + k_q;
        end
        OP_RGET_C: begin
          w0_en = 1'b1; dp_n = dp_q + sptr_t'(1); pc_n = pcl; acc_n = r_q;
        end
        OP_RSET_C: begin
          pc_n = pcl; rw_en = 1'b1; rw_addr = rp_q - sptr_t'(1) - k_q[STACK_AW-1:0];
          rw_data = acc_q; acc_n = v1_q; dp_n = dp_q - sptr_t'(1);
        end
        OP_TWODUP: begin
          pc_n = pc_q + 32'd2; w0_en = 1'b1; w1_en = 1'b1; dp_n = dp_q + sptr_t'(2);
        end
        OP_LIT: begin
          w0_en = 1'b1; dp_n = dp_q + sptr_t'(1); acc_n = k_q; pc_n = pcl;
        end
        OP_LITS: begin
          acc_n = (acc_q << LITS_SHIFT) | k_q; pc_n = pcl;
        end
        OP_RET: begin
          pc_n = r_q; rp_n = rp_q - sptr_t'(1);
        end
        OP_JSR: begin
          rw_en = 1'b1; rw_data = pc1; rp_n = rp_q + sptr_t'(1);
          pc_n = pc1 + acc_q; acc_n = v1_q; dp_n = dp_q - sptr_t'(1);
        end
        OP_JMP: begin
          pc_n = pc1 + acc_q; acc_n = v1_q; dp_n = dp_q - sptr_t'(1);
        end
        OP_JZ: begin
          pc_n = (v1_q == '0) ? pc1 + acc_q : pc1; acc_n = v2_q; dp_n = dp_q - sptr_t'(2);
        end
        OP_EQ0: begin
          pc_n = pc1; acc_n = (acc_q == '0) ? TRUE_WORD : '0;
        end
        OP_EQ, OP_ULT, OP_LT, OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB,
        OP_SHL, OP_USHR, OP_SHR, OP_SIGNE, OP_DROP: begin
          pc_n = pc1; dp_n = dp_q - sptr_t'(1);
          case (op_e'(op_q))
            OP_EQ:    acc_n = (v1_q == acc_q) ? TRUE_WORD : '0;
            OP_ULT:   acc_n = (v1_q < acc_q) ? TRUE_WORD : '0;
            OP_LT:    acc_n = ($signed(v1_q) < $signed(acc_q)) ? TRUE_WORD : '0;
            OP_AND:   acc_n = acc_q & v1_q;
            OP_OR:    acc_n = acc_q | v1_q;
            OP_XOR:   acc_n = acc_q ^ v1_q;
            OP_ADD:   acc_n = acc_q + v1_q;
            OP_SUB:   acc_n = v1_q - acc_q;
            OP_SHL:   acc_n = v1_q << acc_q[4:0];
            OP_USHR:  acc_n = v1_q >> acc_q[4:0];
            OP_SHR:   acc_n = 32'($signed(v1_q) >>> acc_q[4:0]);
            OP_SIGNE: acc_n = sext;
            default:  acc_n = v1_q;
          endcase
        end
        OP_CSEL: begin
          pc_n = pc1; acc_n = (acc_q != '0) ? v1_q : v2_q; dp_n = dp_q - sptr_t'(2);
        end
        OP_UMUL: begin
          pc_n = pc1; w0_en = 1'b1; w0_addr = dp_q - sptr_t'(1);
          w0_data = prod_q[31:0]; acc_n = prod_q[63:32];
        end
        OP_UDIV: begin
          if (acc_q == '0) begin
            trap = 1'b1; trap_code = code_dbz_q;
          end else begin
            pc_n = pc1; w0_en = 1'b1; w0_addr = dp_q - sptr_t'(1);
            w0_data = rem_q; acc_n = quo_q;
          end
        end
        OP_RD, OP_RDB: begin
          pc_n = pc1; maddr_n = acc_q;
          mop_n = (op_e'(op_q) == OP_RD) ? MEM_RD_WORD : MEM_RD_BYTE;
        end
        OP_WRT, OP_WRTB: begin
          pc_n = pc1; maddr_n = acc_q; acc_n = v2_q; dp_n = dp_q - sptr_t'(2);
          if (op_e'(op_q) == OP_WRT) begin
            mop_n = MEM_WR_WORD; mdata_n = v1_q;
          end else begin
            mop_n = MEM_WR_BYTE; mdata_n = {24'd0, v1_q[7:0]};
          end
        end
        OP_NOP: pc_n = pcl;
        OP_DUP: begin
          pc_n = pc1; w0_en = 1'b1; dp_n = dp_q + sptr_t'(1);
        end
        OP_SWAP: begin
          pc_n = pc1; w0_en = 1'b1; w0_addr = dp_q - sptr_t'(1); acc_n = v1_q;
        end
        OP_OVER: begin
          pc_n = pc1; w0_en = 1'b1; dp_n = dp_q + sptr_t'(1); acc_n = v1_q;
        end
        OP_ROT: begin
          pc_n = pc1; w0_en = 1'b1; w0_addr = dp_q - sptr_t'(2); w0_data = v1_q;
          w1_en = 1'b1; w1_addr = dp_q - sptr_t'(1); w1_data = acc_q; acc_n = v2_q;
        end
        OP_RTO: begin
          pc_n = pc1; rw_en = 1'b1; rw_data = acc_q; rp_n = rp_q + sptr_t'(1);
          acc_n = v1_q; dp_n = dp_q - sptr_t'(1);
        end
        OP_RFROM: begin
          pc_n = pc1; w0_en = 1'b1; dp_n = dp_q + sptr_t'(1);
          acc_n = r_q; rp_n = rp_q - sptr_t'(1);
        end
        OP_RGET: begin
          pc_n = pc1; acc_n = r_q;
        end
        OP_RSET: begin
          pc_n = pc1; rw_en = 1'b1; rw_addr = rp_q - sptr_t'(1) - acc_q[STACK_AW-1:0];
          rw_data = v1_q; acc_n = v2_q; dp_n = dp_q - sptr_t'(2);
        end
        OP_LOAD_RETURN: acc_n = k_q;
        OP_REARM: armed_n = 1'b1;
        default: trap = 1'b1;
      endcase
      if (trap) begin
        if (armed_q) begin
          w0_en = 1'b1; w0_addr = dp_q; w0_data = acc_q; dp_n = dp_q + sptr_t'(1);
          acc_n = trap_code;
          rw_en = 1'b1; rw_addr = rp_q; rw_data = pc_q; rp_n = rp_q + sptr_t'(1);
          pc_n = trap_start_q; armed_n = 1'b0;
        end else begin
          stopped_n = 1'b1; hcode_n = trap_code;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      acc_q     <= '0;
      dp_q      <= '0;
      rp_q      <= '0;
      armed_q   <= 1'b1;
      stopped_q <= 1'b0;
      hcode_q   <= '0;
    end else if (cmd_i.exec) begin
      pc_q      <= pc_n;
      acc_q     <= acc_n;
      dp_q      <= dp_n;
      rp_q      <= rp_n;
      armed_q   <= armed_n;
      stopped_q <= stopped_n;
      hcode_q   <= hcode_n;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pc_q    <= pc_q;
      out_acc_q   <= acc_q;
      out_mop_q   <= mop_q;
      out_maddr_q <= maddr_q;
      out_mdata_q <= mdata_q;
      out_halt_q  <= stopped_q;
      out_hcode_q <= hcode_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign next_pc_o   = out_pc_q;
  assign acc_out_o   = out_acc_q;
  assign mem_op_o    = out_mop_q;
  assign mem_addr_o  = out_maddr_q;
  assign mem_wdata_o = out_mdata_q;
  assign halted_o    = out_halt_q;
  assign halt_code_o = out_hcode_q;

  assign stat_o.is_mul   = !stopped_q && (op_e'(op_q) == OP_UMUL);
  assign stat_o.is_div   = !stopped_q && (op_e'(op_q) == OP_UDIV) && (acc_q != '0);
  assign stat_o.div_last = (dcnt_q == 5'd31);
  assign stat_o.has_w1   = !stopped_q && ((op_e'(op_q) == OP_TWODUP) || (op_e'(op_q) == OP_ROT));
  assign stat_o.out_busy = out_vld_q && out_stall_i;

endmodule

// ===== src/smc_ctrl.sv =====
// controller state machine sequencing stack reads, execute units and writes
// depends on smc_pkg
module smc_ctrl import smc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd_o.rd_sel = RD_TOP;
        state_d      = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_sel    = RD_SECOND;
        cmd_o.cap_first = 1'b1;
        state_d         = ST_RD_C;
      end
      ST_RD_C: begin
        cmd_o.cap_second = 1'b1;
        if (stat_i.is_mul) begin
          state_d = ST_MUL;
        end else if (stat_i.is_div) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.has_w1 ? ST_WR2 : ST_OUT;
      end
      ST_WR2: begin
        cmd_o.wr_second = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/stack_machine_execute_core.sv =====
// channel | signals                                   | flow
// in      | in_valid_i, in_stall_o, opcode_i ...     | instruction item in
// out     | out_valid_o, out_stall_i, next_pc_o ...  | result item out
// cfg     | cfg_valid_i, cfg_ready_o, index, data    | register write
// an item passes rd_a, rd_b, rd_c, exec and out to the result register; twodup
// and rot add wr2, umul adds mul, nonzero udiv adds div (one quotient bit per cycle)
// the stack ram ports set the read and write steps; one item is in flight at a time
// the next item is taken while a result still waits; a stalled result holds the
// item after it at the final step
// reset is asynchronous and active low, no clearing pass on the stacks
// top level of the stack machine execute core; depends on smc_pkg, smc_ctrl,
// smc_datapath and stack_machine_execute_core_assert.svh
`include "stack_machine_execute_core_assert.svh"
module stack_machine_execute_core import smc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  opcode_i,
  input  logic [31:0] constant_i,
  input  logic [11:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [31:0] acc_out_o,
  output logic [2:0]  mem_op_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] mem_wdata_o,
  output logic        halted_o,
  output logic [31:0] halt_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  smc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .cmd_o(cmd)
  );

  smc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .opcode_i, .constant_i, .length_i,
    .out_valid_o, .out_stall_i,
    .next_pc_o, .acc_out_o, .mem_op_o, .mem_addr_o, .mem_wdata_o,
    .halted_o, .halt_code_o
  );

  `SMC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "item accepted while another is in flight")
  `SMC_ASSERT_IMP(a_halt_no_mem, out_valid_o && halted_o, mem_op_o == MEM_NONE,
    "memory request from a halted machine")
  `SMC_ASSERT_IMP(a_wdata_zero,
    out_valid_o && (mem_op_o == MEM_NONE || mem_op_o == MEM_RD_WORD || mem_op_o == MEM_RD_BYTE),
    mem_wdata_o == '0, "write data on a non-write result")
  `SMC_ASSERT_IMP(a_load_on_free, cmd.load_out, !(out_valid_o && out_stall_i),
    "result register overwritten while stalled")

endmodule
